/* hdl/fixed_point_to_double_convert_defines.svh */
// Assertion macros for the fixed-point to double converter.
// Depends on nothing; included by the top level.
`ifndef FIXED_POINT_TO_DOUBLE_CONVERT_DEFINES_SVH
`define FIXED_POINT_TO_DOUBLE_CONVERT_DEFINES_SVH
`ifndef SYNTHESIS
`define FPD_ASSERT(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);
`define FPD_ASSERT_NR(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) prop) else $error(msg);
`else
`define FPD_ASSERT(label, clk_sig, rst_sig, prop, msg)
`define FPD_ASSERT_NR(label, clk_sig, prop, msg)
`endif
`endif

/* hdl/fpd_pkg.sv */
// Shared constants and types for the fixed-point to double converter.
// No dependencies.
`timescale 1ns / 1ps
package fpd_pkg;
  localparam int unsigned MANT_BITS = 52;
  localparam int unsigned EXP_BIAS  = 1023;
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned IDX_W     = 2;
  localparam int unsigned DBL_W     = 64;
  localparam logic [IDX_W-1:0] REG_SIGNED = 2'd0;
  localparam logic [IDX_W-1:0] REG_INT    = 2'd1;
  localparam logic [IDX_W-1:0] REG_FRAC   = 2'd2;
  typedef struct packed {
    logic             signed_format;
    logic [CFG_W-1:0] int_bits;
    logic [CFG_W-1:0] frac_bits;
  } cfg_t;
endpackage

/* hdl/fpd_stream_if.sv */
// Valid/ready channel with a generic payload.
// No dependencies.
`timescale 1ns / 1ps
interface fpd_stream_if #(parameter int unsigned W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/fpd_cfg_if.sv */
// Configuration write channel: register index and write data.
// Depends on fpd_pkg.
`timescale 1ns / 1ps
interface fpd_cfg_if import fpd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [63:0]      value;
  modport source (output valid, output index, output value, input ready);
  modport sink (input valid, input index, input value, output ready);
endinterface

/* hdl/fpd_front.sv */
// Stage 1: mask the word to the format, take the two's complement magnitude.
// Depends on fpd_pkg.
`timescale 1ns / 1ps
module fpd_front import fpd_pkg::*; #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 in_valid,
  input  logic [WORD_BITS-1:0] raw_word,
  input  cfg_t                 cfg,
  output logic                 valid,
  output logic                 neg,
  output logic                 invalid,
  output logic [WORD_BITS-1:0] mag,
  output logic [CFG_W-1:0]     frac_bits
);
  localparam int unsigned SUM_W = CFG_W + 1;
  logic [SUM_W-1:0]     body;
  logic [SUM_W-1:0]     total;
  logic [WORD_BITS:0]   mask;
  logic [WORD_BITS:0]   shifted;
  logic [WORD_BITS-1:0] m;
  logic                 sbit;
  logic                 bad;

  always_comb begin
    body    = SUM_W'(cfg.int_bits) + SUM_W'(cfg.frac_bits);
    total   = body + SUM_W'(cfg.signed_format);
    bad     = total > SUM_W'(WORD_BITS);
    // mask of body ones; body <= WORD_BITS when valid
    mask    = ~((WORD_BITS+1)'({(WORD_BITS+1){1'b1}}) << body);
    m       = raw_word & mask[WORD_BITS-1:0];
    // bit just above the body; zero once the body fills the word
    shifted = {1'b0, raw_word} >> body;
    sbit    = shifted[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      neg       <= !bad && cfg.signed_format && sbit && (body < SUM_W'(WORD_BITS));
      invalid   <= bad;
      // 2^body - m; a zero m with sign set at body=width never occurs (sign needs room)
      mag       <= bad ? '0 :
                   (cfg.signed_format && sbit && (body < SUM_W'(WORD_BITS))) ?
                   WORD_BITS'(mask[WORD_BITS-1:0] - m + 1'b1) : m;
      frac_bits <= cfg.frac_bits;
    end
  end
endmodule

/* hdl/fpd_lzc.sv */
// Stage 2: find the top set bit of the magnitude.
// Depends on fpd_pkg.
`timescale 1ns / 1ps
module fpd_lzc import fpd_pkg::*; #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic                         in_valid,
  input  logic                         in_neg,
  input  logic                         in_invalid,
  input  logic [WORD_BITS-1:0]         in_mag,
  input  logic [CFG_W-1:0]             in_frac,
  output logic                         valid,
  output logic                         neg,
  output logic                         invalid,
  output logic                         zero,
  output logic [WORD_BITS-1:0]         mag,
  output logic [CFG_W-1:0]             frac_bits,
  output logic [$clog2(WORD_BITS)-1:0] top
);
  localparam int unsigned P_W = $clog2(WORD_BITS);
  logic [P_W-1:0] p;

  always_comb begin
    p = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (in_mag[i]) p = P_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      neg       <= in_neg;
      invalid   <= in_invalid;
      zero      <= in_mag == '0;
      mag       <= in_mag;
      frac_bits <= in_frac;
      top       <= p;
    end
  end
endmodule

/* hdl/fpd_pack.sv */
// Stage 3: normalize the magnitude and assemble the double pattern.
// Depends on fpd_pkg.
`timescale 1ns / 1ps
module fpd_pack import fpd_pkg::*; #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic                         in_valid,
  input  logic                         in_neg,
  input  logic                         in_invalid,
  input  logic                         in_zero,
  input  logic [WORD_BITS-1:0]         in_mag,
  input  logic [CFG_W-1:0]             in_frac,
  input  logic [$clog2(WORD_BITS)-1:0] in_top,
  output logic                         valid,
  output logic [DBL_W-1:0]             double_bits,
  output logic                         format_invalid
);
  localparam int unsigned SH_W = $clog2(MANT_BITS+1);
  logic [MANT_BITS:0]   norm;
  logic [10:0]          exp_field;
  logic [SH_W-1:0]      sh;

  always_comb begin
    sh        = SH_W'(MANT_BITS) - SH_W'(in_top);
    norm      = (MANT_BITS+1)'(in_mag) << sh;
    exp_field = 11'(EXP_BIAS) + 11'(in_top) - 11'(in_frac);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      format_invalid <= in_invalid;
      double_bits    <= (in_invalid || in_zero) ? '0 :
                        {in_neg, exp_field, norm[MANT_BITS-1:0]};
    end
  end
endmodule

/* hdl/fixed_point_to_double_convert.sv */
// Fixed-point to IEEE 754 double converter, top level.
// Depends on fpd_pkg, fpd_stream_if, fpd_cfg_if, fpd_front, fpd_lzc, fpd_pack.
//
// Usage:
//   in  : raw_word words arrive on a valid/ready sink channel.
//   out : {format_invalid, double_bits} leave on a valid/ready source channel,
//         double_bits in the low 64 bits of the payload.
//   cfg : register writes (0 signed_format, 1 int_bits, 2 frac_bits); write
//         only while the pipe is empty. Other indexes are dropped.
// The pipe takes one word per cycle while the output is not stalled. The
// three stages are mask/negate, top-bit search, then normalize shift and
// pack, each registered, from input transfer to output valid.
// Reset clears the stage valid bits and loads the format: signed, 19
// integer bits, 12 fraction bits.
// When the receiver stalls, all stages hold together (ready falls as soon
// as the last stage is full and blocked), so nothing drops or repeats.
// Too wide a format yields zero with format_invalid set.
`timescale 1ns / 1ps
`include "fixed_point_to_double_convert_defines.svh"
module fixed_point_to_double_convert import fpd_pkg::*; #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  fpd_stream_if.sink       in_ch,
  fpd_stream_if.source     out_ch,
  fpd_cfg_if.sink          cfg_ch
);
  cfg_t cfg;
  logic advance;

  logic                         s1_valid, s1_neg, s1_invalid;
  logic [WORD_BITS-1:0]         s1_mag;
  logic [CFG_W-1:0]             s1_frac;
  logic                         s2_valid, s2_neg, s2_invalid, s2_zero;
  logic [WORD_BITS-1:0]         s2_mag;
  logic [CFG_W-1:0]             s2_frac;
  logic [$clog2(WORD_BITS)-1:0] s2_top;
  logic                         s3_valid, s3_invalid;
  logic [DBL_W-1:0]             s3_bits;

  // advance the whole pipe unless the output holds an untaken result
  assign advance      = !s3_valid || out_ch.ready;
  assign in_ch.ready  = advance;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = s3_valid;
  assign out_ch.data  = {s3_invalid, s3_bits};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{signed_format: 1'b1, int_bits: 6'd19, frac_bits: 6'd12};
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_SIGNED: cfg.signed_format <= cfg_ch.value[0];
        REG_INT:    cfg.int_bits      <= cfg_ch.value[CFG_W-1:0];
        REG_FRAC:   cfg.frac_bits     <= cfg_ch.value[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  fpd_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk, .rst, .advance,
    .in_valid(in_ch.valid), .raw_word(in_ch.data[WORD_BITS-1:0]), .cfg,
    .valid(s1_valid), .neg(s1_neg), .invalid(s1_invalid), .mag(s1_mag),
    .frac_bits(s1_frac)
  );

  fpd_lzc #(.WORD_BITS(WORD_BITS)) u_lzc (
    .clk, .rst, .advance,
    .in_valid(s1_valid), .in_neg(s1_neg), .in_invalid(s1_invalid),
    .in_mag(s1_mag), .in_frac(s1_frac),
    .valid(s2_valid), .neg(s2_neg), .invalid(s2_invalid), .zero(s2_zero),
    .mag(s2_mag), .frac_bits(s2_frac), .top(s2_top)
  );

  fpd_pack #(.WORD_BITS(WORD_BITS)) u_pack (
    .clk, .rst, .advance,
    .in_valid(s2_valid), .in_neg(s2_neg), .in_invalid(s2_invalid),
    .in_zero(s2_zero), .in_mag(s2_mag), .in_frac(s2_frac), .in_top(s2_top),
    .valid(s3_valid), .double_bits(s3_bits), .format_invalid(s3_invalid)
  );

  `FPD_ASSERT(a_invalid_zero, clk, rst, out_ch.valid && out_ch.data[DBL_W] |-> out_ch.data[DBL_W-1:0] == '0, "invalid result not zero")
  `FPD_ASSERT(a_hold, clk, rst, s3_valid && !out_ch.ready |=> s3_valid && $stable(s3_bits), "stalled result changed")
  `FPD_ASSERT(a_top_set, clk, rst, s2_valid && !s2_zero |-> s2_mag[s2_top], "top bit not set")
endmodule

/* tb/fixed_point_to_double_convert_tb.sv */
// Testbench for the fixed-point to double converter: drives raw words through
// several formats and checks each result against an in-bench predictor or a typed-in result.
// Depends on fpd_pkg, fpd_stream_if, fpd_cfg_if and the converter top level.
`timescale 1ns / 1ps
module fixed_point_to_double_convert_tb;
  import fpd_pkg::*;

  localparam int unsigned WBITS      = 32;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [IDX_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic        invalid;
    logic [63:0] bits;
  } dbl_res_t;

  // One directed row: a word, and where known at a glance, the result.
  typedef struct {
    logic [31:0] word;
    bit          known;
    dbl_res_t    res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fpd_stream_if #(.W(32)) in_ch ();
  fpd_stream_if #(.W(65)) out_ch ();
  fpd_cfg_if cfg_ch ();

  fixed_point_to_double_convert #(.WORD_BITS(WBITS)) dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Format as the predictor sees it
  logic             fmt_signed;
  logic [CFG_W-1:0] fmt_int;
  logic [CFG_W-1:0] fmt_frac;

  dbl_res_t expected_dbl[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Compute the exact double of one raw word under the current format.
  function automatic dbl_res_t convert_word(logic [31:0] raw);
    dbl_res_t r;
    int unsigned width;
    logic [63:0] field, mag;
    int top;
    width = fmt_int + fmt_frac;
    r = '0;
    if (width + fmt_signed > WBITS) begin
      r.invalid = 1'b1;
      return r;
    end
    field = {32'd0, raw} & ((64'd1 << width) - 64'd1);
    mag = field;
    if (fmt_signed && ((({32'd0, raw} >> width) & 64'd1) != 0)) begin
      r.bits[63] = 1'b1;
      mag = (64'd1 << width) - field;
    end
    if (mag == 0) return '0;
    top = 0;
    for (int i = 0; i < 64; i++) if (mag[i]) top = i;
    r.bits[62:52] = 11'(EXP_BIAS + top - fmt_frac);
    r.bits[51:0] = 52'(mag << (MANT_BITS - top));
    return r;
  endfunction

  task automatic report_mismatch(string what, dbl_res_t got, dbl_res_t want);
    $display("ERROR %0t: %s got inv=%0b bits=%h want inv=%0b bits=%h",
             $time, what, got.invalid, got.bits, want.invalid, want.bits);
    mismatches++;
  endtask

  // Receiver side: random stalls, check every transfer at the rising edge.
  initial out_ch.ready = 1'b0;
  always @(negedge clk) begin
    if (!rst) out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_dbl.size() == 0)
          report_mismatch("unexpected result", dbl_res_t'(out_ch.data), '0);
        else begin
          dbl_res_t want;
          want = expected_dbl.pop_front();
          if (out_ch.data[64] !== want.invalid)
            report_mismatch("format_invalid", dbl_res_t'(out_ch.data), want);
          else if (out_ch.data[63:0] !== want.bits)
            report_mismatch("double_bits", dbl_res_t'(out_ch.data), want);
        end
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long.
  always @(posedge clk) begin
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Send one word; push the prediction (or a typed-in result) at the transfer.
  // Returns at the falling edge after the transfer with valid still high, so
  // the next word can follow without a gap; drain_pipe drops valid.
  task automatic send_word(logic [31:0] w, bit known = 0, dbl_res_t res = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_dbl.push_back(known ? res : convert_word(w));
    @(negedge clk);
  endtask

  // Write one register; only called with the pipe drained. Leaves valid high
  // for a following write; the caller drops it.
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.value <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_SIGNED: fmt_signed = val[0];
      REG_INT:    fmt_int = val[CFG_W-1:0];
      REG_FRAC:   fmt_frac = val[CFG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    while (expected_dbl.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_format(bit s, int unsigned ib, int unsigned fb);
    drain_pipe();
    write_reg(REG_SIGNED, 64'(s));
    write_reg(REG_INT, 64'(ib));
    write_reg(REG_FRAC, 64'(fb));
    cfg_ch.valid <= 1'b0;
  endtask

  // Random word: biased toward edges of the format, sign bit and zero.
  function automatic logic [31:0] random_word();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1 << $urandom_range(31);
      3: return ~(32'd1 << $urandom_range(31));
      default: return $urandom();
    endcase
  endfunction

  stim_row_t directed[$];

  initial begin
    fmt_signed = 1'b1;
    fmt_int = 6'd19;
    fmt_frac = 6'd12;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_SIGNED;
    cfg_ch.value = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows under the reset format (signed, 19.12, sign at bit 31).
    directed.push_back('{32'h0000_0000, 1, '{1'b0, 64'h0}});                // zero
    directed.push_back('{32'h0000_1000, 1, '{1'b0, 64'h3FF0_0000_0000_0000}}); // 1.0
    directed.push_back('{32'hFFFF_F000, 1, '{1'b0, 64'hBFF0_0000_0000_0000}}); // -1.0
    directed.push_back('{32'h8000_0000, 1, '{1'b0, 64'hC120_0000_0000_0000}}); // most negative
    directed.push_back('{32'hFFFF_FFFF, 1, '{1'b0, 64'hBF30_0000_0000_0000}}); // -2^-12
    directed.push_back('{32'h4000_0000, 1, '{1'b0, 64'h4110_0000_0000_0000}}); // 2^18
    directed.push_back('{32'h7FFF_FFFF, 0, '0});
    directed.push_back('{32'h0000_0001, 1, '{1'b0, 64'h3F30_0000_0000_0000}}); // 2^-12
    directed.push_back('{32'hA5A5_5A5A, 0, '0});
    foreach (directed[i]) send_word(directed[i].word, directed[i].known, directed[i].res);

    // Extremes: 32-bit unsigned integer, too-wide formats, zero-width.
    set_format(0, 32, 0);
    send_word(32'hFFFF_FFFF, 1, '{1'b0, 64'h41EF_FFFF_FFE0_0000});
    send_word(32'h8000_0000, 1, '{1'b0, 64'h41E0_0000_0000_0000});
    set_format(1, 32, 0);
    send_word(32'h1234_5678, 1, '{1'b1, 64'h0});
    set_format(0, 63, 63);
    send_word(32'h1, 1, '{1'b1, 64'h0});
    set_format(1, 0, 0);
    send_word(32'h0, 1, '{1'b0, 64'h0});
    send_word(32'h1, 1, '{1'b0, 64'hBFF0_0000_0000_0000}); // sign bit alone: -1
    set_format(0, 0, 32);
    send_word(32'h0000_0001, 1, '{1'b0, 64'h3DF0_0000_0000_0000});
    send_word(32'hFFFF_FFFF, 0);
    set_format(1, 0, 31);
    send_word(32'h8000_0000, 0);
    send_word(32'h4000_0000, 0);
    // Out-of-range index and oversized value: only low bits kept.
    drain_pipe();
    write_reg(REG_NONE, 64'hFFFF);
    write_reg(REG_SIGNED, 64'hFFFF_FFFF_FFFF_FFFE);
    cfg_ch.valid <= 1'b0;
    send_word(32'hDEAD_BEEF, 0);

    // Random formats in three phases of sender idling and receiver stalls (none in the last); mostly valid formats.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 26 : (ph == 1) ? 56 : 0;
      recv_stall_pct = (ph == 0) ? 56 : (ph == 1) ? 26 : 0;
      for (int f = 0; f < 6; f++) begin
        bit s;
        int unsigned ib, fb;
        s = $urandom_range(1);
        if ($urandom_range(7) == 0) begin
          ib = $urandom_range(63);
          fb = $urandom_range(63);
        end else begin
          ib = $urandom_range(WBITS - s);
          fb = $urandom_range(WBITS - s - ib);
        end
        set_format(s, ib, fb);
        repeat (30) send_word(random_word());
      end
    end

    drain_pipe();
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
